// ----- rtl/rwrs_pkg.sv -----
// Shared types and constants of the read/write request scheduler.
package rwrs_pkg;

  localparam int unsigned BlockBits  = 64;
  localparam int unsigned ElemBits   = 16;
  localparam int unsigned DataW      = 64;
  localparam int unsigned LevelW     = 7;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned FifoDepth  = 2;

  localparam int unsigned UsedBits = (BlockBits / ElemBits) * ElemBits;
  localparam logic [DataW-1:0] BlockMask =
    (UsedBits >= DataW) ? {DataW{1'b1}} : ((DataW'(1) << UsedBits) - DataW'(1));

  localparam logic [LevelW-1:0] ThresholdReset = LevelW'(16);

  typedef enum logic [CfgIndexW-1:0] {
    CfgReadThreshold  = 2'd0,
    CfgWriteThreshold = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    StWait   = 2'd0,
    StReadA  = 2'd1,
    StReadB  = 2'd2,
    StWriteC = 2'd3
  } mover_state_e;

  typedef enum logic [2:0] {
    ActIdle   = 3'd0,
    ActPushA  = 3'd1,
    ActPushB  = 3'd2,
    ActReadA  = 3'd3,
    ActReadB  = 3'd4,
    ActWriteC = 3'd5,
    ActEnd    = 3'd6
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [DataW-1:0] payload;
    logic             has_end;
  } tick_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- rtl/read_write_request_scheduler_core.sv -----
// Top level of the read/write request scheduler.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  cfg     | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/ready_o    | resp_*, accel_finish_i, level_*, c_block_i
//  out     | out       | out_valid_o/ready_i   | action_o, payload_o, end_of_run_o
//
// One tick transaction is accepted per cycle while the result queue has room.
// An accepted tick writes its first result into the result queue; the final tick also
// yields the end notice one output transaction later.
// Once halted, ticks are still accepted and dropped. Config writes complete at once.
// Reset returns the mover to waiting and both thresholds to 16.
module read_write_request_scheduler_core #(
  parameter int unsigned FIFO_DEPTH = rwrs_pkg::FifoDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rwrs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rwrs_pkg::LevelW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           resp_valid_i,
  input  logic                           resp_queue_i,
  input  logic                           resp_last_i,
  input  logic [rwrs_pkg::DataW-1:0]     resp_block_i,
  input  logic                           accel_finish_i,
  input  logic [rwrs_pkg::LevelW-1:0]    level_a_i,
  input  logic [rwrs_pkg::LevelW-1:0]    level_b_i,
  input  logic [rwrs_pkg::LevelW-1:0]    level_c_i,
  input  logic [rwrs_pkg::DataW-1:0]     c_block_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     action_o,
  output logic [rwrs_pkg::DataW-1:0]     payload_o,
  output logic                           end_of_run_o
);
  import rwrs_pkg::*;

  logic         push, pop;
  tick_res_t    push_data, head;
  fifo_status_t fifo_status;

  rwrs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .resp_valid_i   (resp_valid_i),
    .resp_queue_i   (resp_queue_i),
    .resp_last_i    (resp_last_i),
    .resp_block_i   (resp_block_i),
    .accel_finish_i (accel_finish_i),
    .level_a_i      (level_a_i),
    .level_b_i      (level_b_i),
    .level_c_i      (level_c_i),
    .c_block_i      (c_block_i),
    .fifo_status_i  (fifo_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  rwrs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  rwrs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .payload_o     (payload_o),
    .end_of_run_o  (end_of_run_o)
  );

endmodule

// ----- rtl/rwrs_front.sv -----
// Front end: accepts ticks, runs the mover state machine and classifies results.
module rwrs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rwrs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rwrs_pkg::LevelW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         resp_valid_i,
  input  logic                         resp_queue_i,
  input  logic                         resp_last_i,
  input  logic [rwrs_pkg::DataW-1:0]   resp_block_i,
  input  logic                         accel_finish_i,
  input  logic [rwrs_pkg::LevelW-1:0]  level_a_i,
  input  logic [rwrs_pkg::LevelW-1:0]  level_b_i,
  input  logic [rwrs_pkg::LevelW-1:0]  level_c_i,
  input  logic [rwrs_pkg::DataW-1:0]   c_block_i,
  input  rwrs_pkg::fifo_status_t       fifo_status_i,
  output logic                         push_o,
  output rwrs_pkg::tick_res_t          push_data_o
);
  import rwrs_pkg::*;

  mover_state_e     state_q, state_d;
  logic [1:0]       pend_q, pend_d;
  logic [1:0]       done_q, done_d;
  logic             fin_q, fin_d;
  logic             halt_q, halt_d;
  logic [LevelW-1:0] rd_thr_q, wr_thr_q;
  logic             want_a, want_b, want_c;
  logic             take;
  tick_res_t        res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = halt_q || !fifo_status_i.full;
  assign take        = in_valid_i && in_ready_o;
  assign push_o      = take && !halt_q;
  assign push_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_thr_q <= ThresholdReset;
      wr_thr_q <= ThresholdReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgReadThreshold:  rd_thr_q <= cfg_data_i;
        CfgWriteThreshold: wr_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StWait;
      pend_q  <= 2'b00;
      done_q  <= 2'b00;
      fin_q   <= 1'b0;
      halt_q  <= 1'b0;
    end else if (take && !halt_q) begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      fin_q   <= fin_d;
      halt_q  <= halt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    done_d      = done_q;
    fin_d       = fin_q;
    res.action  = ActIdle;
    res.payload = '0;

    unique case (state_q)
      StWait: begin
        if (resp_valid_i) begin
          res.action  = resp_queue_i ? ActPushB : ActPushA;
          res.payload = resp_block_i & BlockMask;
          if (resp_last_i) begin
            done_d[resp_queue_i] = 1'b1;
          end
          pend_d[resp_queue_i] = 1'b0;
        end else if (accel_finish_i) begin
          fin_d = 1'b1;
        end
      end
      StReadA: begin
        res.action  = ActReadA;
        res.payload = DataW'(BlockBits);
        pend_d[0]   = 1'b1;
      end
      StReadB: begin
        res.action  = ActReadB;
        res.payload = DataW'(BlockBits);
        pend_d[1]   = 1'b1;
      end
      StWriteC: begin
        res.action  = ActWriteC;
        res.payload = c_block_i & BlockMask;
      end
      default: ;
    endcase

    want_a = (level_a_i < rd_thr_q) && !done_d[0] && !pend_d[0];
    want_b = (level_b_i < rd_thr_q) && !done_d[1] && !pend_d[1];
    want_c = (level_c_i != '0) && ((level_c_i > wr_thr_q) || (done_d[0] && done_d[1]));

    unique case (state_q)
      StWait: begin
        if (want_a)      state_d = StReadA;
        else if (want_b) state_d = StReadB;
        else if (want_c) state_d = StWriteC;
        else             state_d = StWait;
      end
      StReadA: begin
        if (want_b)      state_d = StReadB;
        else if (want_c) state_d = StWriteC;
        else             state_d = StWait;
      end
      StReadB: begin
        if (want_c)      state_d = StWriteC;
        else if (want_a) state_d = StReadA;
        else             state_d = StWait;
      end
      StWriteC: begin
        if (want_a)      state_d = StReadA;
        else if (want_b) state_d = StReadB;
        else             state_d = StWait;
      end
      default: state_d = StWait;
    endcase

    res.has_end = fin_d && (level_c_i == '0);
    halt_d      = halt_q || res.has_end;
  end

endmodule

// ----- rtl/rwrs_fifo.sv -----
// Short result queue between the front and back ends.
module rwrs_fifo #(
  parameter int unsigned DEPTH = rwrs_pkg::FifoDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rwrs_pkg::tick_res_t    push_data_i,
  input  logic                   pop_i,
  output rwrs_pkg::tick_res_t    head_o,
  output rwrs_pkg::fifo_status_t status_o
);
  import rwrs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tick_res_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/rwrs_back.sv -----
// Back end: drains queued tick results and appends the end notice.
module rwrs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rwrs_pkg::tick_res_t        head_i,
  input  rwrs_pkg::fifo_status_t     fifo_status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 action_o,
  output logic [rwrs_pkg::DataW-1:0] payload_o,
  output logic                       end_of_run_o
);
  import rwrs_pkg::*;

  logic phase_q, phase_d;
  logic take;

  assign out_valid_o  = !fifo_status_i.empty;
  assign take         = out_valid_o && out_ready_i;
  assign action_o     = phase_q ? ActEnd : head_i.action;
  assign payload_o    = phase_q ? '0 : head_i.payload;
  assign end_of_run_o = phase_q || !head_i.has_end;
  assign pop_o        = take && end_of_run_o;

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      phase_d = !phase_q && head_i.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the read/write request scheduler core.
`timescale 1ns / 100ps

module tb_top;
  import rwrs_pkg::*;

  typedef struct packed {
    logic              resp_valid;
    logic              resp_queue;
    logic              resp_last;
    logic [DataW-1:0]  resp_block;
    logic              accel_finish;
    logic [LevelW-1:0] level_a;
    logic [LevelW-1:0] level_b;
    logic [LevelW-1:0] level_c;
    logic [DataW-1:0]  c_block;
  } tick_t;

  typedef struct packed {
    action_e          action;
    logic [DataW-1:0] payload;
    logic             end_mark;
  } sched_res_t;

  typedef struct packed {
    tick_t      tick;
    logic       typed;
    sched_res_t res;
  } dir_row_t;

  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxSparse,
    RxToggle
  } rx_mode_e;

  localparam logic [CfgIndexW-1:0] CfgSpare0 = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgSpare1 = 2'd3;
  localparam logic [DataW-1:0]     Ones      = '1;
  localparam logic [DataW-1:0]     ReadSize  = DataW'(BlockBits);
  localparam logic [LevelW-1:0]    QueueFull = LevelW'(64);
  localparam logic [LevelW-1:0]    LevelMax  = '1;
  localparam int unsigned HoldOffAfter  = 300;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned SettleCycles  = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [LevelW-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 resp_valid_i;
  logic                 resp_queue_i;
  logic                 resp_last_i;
  logic [DataW-1:0]     resp_block_i;
  logic                 accel_finish_i;
  logic [LevelW-1:0]    level_a_i;
  logic [LevelW-1:0]    level_b_i;
  logic [LevelW-1:0]    level_c_i;
  logic [DataW-1:0]     c_block_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           action_o;
  logic [DataW-1:0]     payload_o;
  logic                 end_of_run_o;

  // scheduler shadow state
  mover_state_e      mv_state;
  logic [1:0]        rd_pend;
  logic [1:0]        in_done;
  logic              fin_seen;
  logic              halted_flag;
  logic              resp_taken;
  logic [LevelW-1:0] rd_thr;
  logic [LevelW-1:0] wr_thr;

  sched_res_t  expected_q[$];
  tick_t       cur_tick;
  logic        cur_typed;
  sched_res_t  cur_expect;
  int unsigned ticks_accepted;
  int unsigned err_count;
  logic        held_off;

  assign resp_valid_i   = cur_tick.resp_valid;
  assign resp_queue_i   = cur_tick.resp_queue;
  assign resp_last_i    = cur_tick.resp_last;
  assign resp_block_i   = cur_tick.resp_block;
  assign accel_finish_i = cur_tick.accel_finish;
  assign level_a_i      = cur_tick.level_a;
  assign level_b_i      = cur_tick.level_b;
  assign level_c_i      = cur_tick.level_c;
  assign c_block_i      = cur_tick.c_block;

  read_write_request_scheduler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .resp_valid_i  (resp_valid_i),
    .resp_queue_i  (resp_queue_i),
    .resp_last_i   (resp_last_i),
    .resp_block_i  (resp_block_i),
    .accel_finish_i(accel_finish_i),
    .level_a_i     (level_a_i),
    .level_b_i     (level_b_i),
    .level_c_i     (level_c_i),
    .c_block_i     (c_block_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .payload_o     (payload_o),
    .end_of_run_o  (end_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void schedule_tick(input tick_t t);
    action_e    act;
    logic [DataW-1:0] data;
    logic       want_a;
    logic       want_b;
    logic       want_c;
    logic       end_now;
    sched_res_t r;
    act = ActIdle;
    data = '0;
    resp_taken = 1'b0;
    if (halted_flag) return;
    case (mv_state)
      StWait: begin
        if (t.resp_valid) begin
          act = t.resp_queue ? ActPushB : ActPushA;
          data = t.resp_block & BlockMask;
          if (t.resp_last) in_done[t.resp_queue] = 1'b1;
          rd_pend[t.resp_queue] = 1'b0;
          resp_taken = 1'b1;
        end else if (t.accel_finish) begin
          fin_seen = 1'b1;
        end
      end
      StReadA: begin
        act = ActReadA;
        data = ReadSize;
        rd_pend[0] = 1'b1;
      end
      StReadB: begin
        act = ActReadB;
        data = ReadSize;
        rd_pend[1] = 1'b1;
      end
      default: begin
        act = ActWriteC;
        data = t.c_block & BlockMask;
      end
    endcase
    want_a = (t.level_a < rd_thr) && !in_done[0] && !rd_pend[0];
    want_b = (t.level_b < rd_thr) && !in_done[1] && !rd_pend[1];
    want_c = (t.level_c != '0) && ((t.level_c > wr_thr) || (in_done[0] && in_done[1]));
    case (mv_state)
      StWait:  mv_state = want_a ? StReadA : want_b ? StReadB : want_c ? StWriteC : StWait;
      StReadA: mv_state = want_b ? StReadB : want_c ? StWriteC : StWait;
      StReadB: mv_state = want_c ? StWriteC : want_a ? StReadA : StWait;
      default: mv_state = want_a ? StReadA : want_b ? StReadB : StWait;
    endcase
    end_now = fin_seen && (t.level_c == '0);
    r.action = act;
    r.payload = data;
    r.end_mark = !end_now;
    expected_q.push_back(r);
    if (end_now) begin
      r.action = ActEnd;
      r.payload = '0;
      r.end_mark = 1'b1;
      expected_q.push_back(r);
      halted_flag = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    sched_res_t exp_res;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgReadThreshold:  rd_thr = cfg_data_i;
          CfgWriteThreshold: wr_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          err_count++;
          if (err_count <= MaxReported)
            $display("unexpected result: action %0d payload %h end %b",
                     action_o, payload_o, end_of_run_o);
        end else begin
          exp_res = expected_q.pop_front();
          if (action_o !== exp_res.action || payload_o !== exp_res.payload ||
              end_of_run_o !== exp_res.end_mark) begin
            err_count++;
            if (err_count <= MaxReported)
              $display("mismatch: expected action %0d payload %h end %b, got %0d %h %b",
                       exp_res.action, exp_res.payload, exp_res.end_mark,
                       action_o, payload_o, end_of_run_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        ticks_accepted++;
        schedule_tick(cur_tick);
        if (cur_typed) expected_q[expected_q.size() - 1] = cur_expect;
      end
    end
  end

  initial begin : receiver
    rx_mode_e    rx_mode;
    int unsigned mode_left;
    out_ready_i = 1'b0;
    held_off = 1'b0;
    rx_mode = RxOpen;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (!held_off && ticks_accepted >= HoldOffAfter) begin
        held_off = 1'b1;
        out_ready_i = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (rx_mode)
        RxOpen:   out_ready_i = 1'b1;
        RxCoin:   out_ready_i = 1'($urandom_range(0, 1));
        RxSparse: out_ready_i = ($urandom_range(0, 3) == 0);
        default:  out_ready_i = !out_ready_i;
      endcase
    end
  end

  function automatic logic [DataW-1:0] rand_block();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return Ones;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LevelW-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return QueueFull;
      2: return LevelW'($urandom_range(65, 127));
      3: return rd_thr + LevelW'($urandom_range(0, 2)) - LevelW'(1);
      4: return wr_thr + LevelW'($urandom_range(0, 2)) - LevelW'(1);
      default: return LevelW'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic tick_t quiet_tick(input logic [LevelW-1:0] la, lb, lc);
    tick_t t;
    t = '0;
    t.resp_queue = 1'($urandom_range(0, 1));
    t.resp_block = rand_block();
    t.level_a = la;
    t.level_b = lb;
    t.level_c = lc;
    t.c_block = rand_block();
    return t;
  endfunction

  function automatic dir_row_t dir_row(input logic rv, rq, input logic [DataW-1:0] rb,
                                       input logic [LevelW-1:0] la, lb, lc,
                                       input logic [DataW-1:0] cb, input logic typed,
                                       input action_e act, input logic [DataW-1:0] pay);
    dir_row_t row;
    row = '0;
    row.tick = quiet_tick(la, lb, lc);
    row.tick.resp_valid = rv;
    row.tick.resp_queue = rq;
    row.tick.resp_block = rb;
    row.tick.c_block = cb;
    row.typed = typed;
    row.res.action = act;
    row.res.payload = pay;
    row.res.end_mark = 1'b1;
    return row;
  endfunction

  function automatic tick_t next_random_tick(input tick_t prev, input logic allow_last);
    tick_t       t;
    int unsigned pick;
    t = quiet_tick(rand_level(), rand_level(), rand_level());
    if (prev.resp_valid && !resp_taken) begin
      // hold the response until a waiting tick takes it
      t.resp_valid = 1'b1;
      t.resp_queue = prev.resp_queue;
      t.resp_last = prev.resp_last;
      t.resp_block = prev.resp_block;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && rd_pend[0]) begin
        t.resp_valid = 1'b1;
        t.resp_queue = 1'b0;
      end else if (pick < 90 && rd_pend[1]) begin
        t.resp_valid = 1'b1;
        t.resp_queue = 1'b1;
      end else if (pick >= 94) begin
        t.resp_valid = 1'b1;
      end
      if (t.resp_valid && allow_last) t.resp_last = ($urandom_range(0, 7) == 0);
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    cur_tick = t;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned max_gap,
                            input logic allow_last);
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      send_tick(next_random_tick(cur_tick, allow_last));
      burst--;
    end
    in_valid_i = 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIndexW-1:0] idx, input logic [LevelW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic reconfigure(input logic [LevelW-1:0] rd, input logic [LevelW-1:0] wr);
    drain_results();
    write_cfg(CfgReadThreshold, rd);
    write_cfg(CfgWriteThreshold, wr);
  endtask

  initial begin : stimulus
    tick_t    t;
    dir_row_t rows[$];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgReadThreshold;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cur_tick = '0;
    cur_typed = 1'b0;
    cur_expect = '0;
    mv_state = StWait;
    rd_pend = '0;
    in_done = '0;
    fin_seen = 1'b0;
    halted_flag = 1'b0;
    resp_taken = 1'b0;
    rd_thr = ThresholdReset;
    wr_thr = ThresholdReset;
    ticks_accepted = 0;
    err_count = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    rows.push_back(dir_row(0, 0, '0, QueueFull, QueueFull, '0, '0, 1, ActIdle, '0));
    rows.push_back(dir_row(1, 0, Ones, QueueFull, QueueFull, '0, '0, 1, ActPushA, Ones));
    rows.push_back(dir_row(1, 1, '0, QueueFull, QueueFull, '0, Ones, 1, ActPushB, '0));
    rows.push_back(dir_row(0, 0, Ones, '0, QueueFull, '0, Ones, 1, ActIdle, '0));
    rows.push_back(dir_row(0, 0, Ones, '0, '0, '0, Ones, 1, ActReadA, ReadSize));
    rows.push_back(dir_row(0, 0, '0, '0, '0, QueueFull, rand_block(), 1, ActReadB, ReadSize));
    rows.push_back(dir_row(0, 0, '0, '0, '0, QueueFull, Ones, 1, ActWriteC, Ones));
    rows.push_back(dir_row(1, 0, 64'h0123_4567_89ab_cdef, 7'd15, LevelMax, LevelMax,
                           '0, 0, ActIdle, '0));
    rows.push_back(dir_row(1, 1, 64'hfedc_ba98_7654_3210, LevelMax, LevelMax, LevelMax,
                           64'h8000_0000_0000_0001, 0, ActIdle, '0));
    rows.push_back(dir_row(1, 1, 64'hfedc_ba98_7654_3210, 7'd16, 7'd16, 7'd16,
                           64'h0000_0000_0000_0001, 0, ActIdle, '0));
    rows.push_back(dir_row(1, 1, 64'hfedc_ba98_7654_3210, '0, '0, 7'd17, '0, 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, '0, '0, 7'd17, rand_block(), 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, QueueFull, QueueFull, 7'd1, rand_block(), 0, ActIdle, '0));
    rows.push_back(dir_row(1, 0, '0, 7'd63, QueueFull, '0, '0, 0, ActIdle, '0));
    rows.push_back(dir_row(1, 1, Ones, QueueFull, 7'd63, '0, '0, 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, LevelMax, LevelMax, LevelMax, Ones, 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, '0, '0, '0, '0, 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, '0, '0, '0, rand_block(), 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, '0, '0, '0, rand_block(), 0, ActIdle, '0));
    rows.push_back(dir_row(0, 0, '0, QueueFull, QueueFull, '0, '0, 0, ActIdle, '0));

    foreach (rows[i]) begin
      cur_typed = rows[i].typed;
      cur_expect = rows[i].res;
      send_tick(rows[i].tick);
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    cur_typed = 1'b0;
    in_valid_i = 1'b0;

    run_random(150, 6, 1'b0);
    reconfigure('0, '0);
    run_random(100, 4, 1'b0);
    reconfigure(QueueFull, QueueFull);
    run_random(120, 0, 1'b0);
    reconfigure(LevelMax, LevelMax);
    write_cfg(CfgSpare0, LevelW'($urandom_range(0, 127)));
    write_cfg(CfgSpare1, LevelW'($urandom_range(0, 127)));
    run_random(100, 2, 1'b0);
    reconfigure(LevelW'($urandom_range(0, 127)), LevelW'($urandom_range(0, 127)));
    run_random(150, 3, 1'b0);
    reconfigure(LevelMax, '0);
    run_random(100, 5, 1'b0);
    reconfigure(ThresholdReset, ThresholdReset);
    run_random(200, 3, 1'b1);

    // close both inputs, then flush C under finish
    for (int q = 0; q < 2; q++) begin
      t = quiet_tick(QueueFull, QueueFull, 7'd5);
      t.resp_valid = 1'b1;
      t.resp_queue = q[0];
      t.resp_last = 1'b1;
      do send_tick(t); while (!resp_taken);
    end
    repeat (4) send_tick(quiet_tick(QueueFull, QueueFull, 7'd5));
    t = quiet_tick(QueueFull, QueueFull, 7'd3);
    t.resp_valid = 1'b1;
    t.accel_finish = 1'b1;
    do send_tick(t); while (!resp_taken);
    repeat (6) begin
      t = quiet_tick(QueueFull, QueueFull, 7'd2);
      t.accel_finish = 1'b1;
      send_tick(t);
    end
    while (!halted_flag) begin
      t = quiet_tick(QueueFull, QueueFull, '0);
      t.accel_finish = 1'b1;
      send_tick(t);
    end
    repeat (5) send_tick(next_random_tick(t, 1'b0));
    in_valid_i = 1'b0;

    drain_results();
    repeat (10) @(negedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
